>>> hdl/t4t_pkg.sv
// Shared types, constants and the capability container table of the Type 4 tag responder.
`timescale 1ns / 1ps

package t4t_pkg;

    localparam int FILE_BYTES_DEF   = 128;
    localparam int MAX_READ_LEN_DEF = 62;
    localparam int QUEUE_DEPTH      = 2;

    localparam int ADDR_W   = 16;
    localparam int LEN_W    = 6;
    localparam int IN_DATA_W = 104;
    localparam int CC_BYTES = 15;

    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_CC   = 2'd1;
    localparam logic [1:0] SEL_NDEF = 2'd2;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STATUS = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [7:0] INS_SELECT = 8'hA4;
    localparam logic [7:0] INS_READ   = 8'hB0;

    localparam logic [7:0] P1_BY_ID   = 8'h00;
    localparam logic [7:0] P1_BY_NAME = 8'h04;
    localparam logic [7:0] P2_FIRST   = 8'h0C;
    localparam logic [7:0] FID_HIGH   = 8'hE1;
    localparam logic [7:0] FID_CC     = 8'h03;
    localparam logic [7:0] FID_NDEF   = 8'h04;
    localparam logic [7:0] LC_FID     = 8'h02;
    localparam logic [7:0] LC_AID     = 8'h07;
    localparam logic [55:0] NDEF_AID  = 56'hD2760000850101;

    localparam logic [7:0] SW_OK1   = 8'h90;
    localparam logic [7:0] SW_OK2   = 8'h00;
    localparam logic [7:0] SW_ERR1  = 8'h6A;
    localparam logic [7:0] SW_NOTF2 = 8'h82;
    localparam logic [7:0] SW_FUNC2 = 8'h81;
    localparam logic [7:0] SW_WARN1 = 8'h62;
    localparam logic [7:0] SW_EOF2  = 8'h82;

    // One classified unit of work handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]        op;
        logic              cc;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [7:0]        sw1;
        logic [7:0]        sw2;
        logic [7:0]        value;
    } desc_t;

    // Capability container contents; bytes past its end read as zero.
    function automatic logic [7:0] cc_byte(input logic [ADDR_W-1:0] a,
                                           input logic [ADDR_W-1:0] fb,
                                           input logic              wp);
        logic [7:0] b;
        begin
            unique case (a)
                16'd0:   b = 8'h00;
                16'd1:   b = 8'h0F;
                16'd2:   b = 8'h20;
                16'd3:   b = 8'h00;
                16'd4:   b = 8'h54;
                16'd5:   b = 8'h00;
                16'd6:   b = 8'hFF;
                16'd7:   b = 8'h04;
                16'd8:   b = 8'h06;
                16'd9:   b = 8'hE1;
                16'd10:  b = 8'h04;
                16'd11:  b = fb[15:8];
                16'd12:  b = fb[7:0];
                16'd13:  b = 8'h00;
                16'd14:  b = wp ? 8'hFF : 8'h00;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

>>> hdl/t4t_fifo.sv
// Two-entry queue of classified work descriptors between front and back end.
`timescale 1ns / 1ps

module t4t_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  t4t_pkg::desc_t push_desc,
    output logic          full,
    input  logic          pop,
    output t4t_pkg::desc_t head,
    output logic          empty
);
    import t4t_pkg::*;

    localparam int Q_AW = $clog2(QUEUE_DEPTH);

    desc_t            entry_reg [QUEUE_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_next;
    logic [Q_AW:0]    count_reg;
    logic [Q_AW:0]    count_next;

    assign full  = (count_reg == (Q_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone write");
`endif

endmodule

>>> hdl/t4t_front.sv
// Front end: accepts input beats, tracks the selected file and classifies each APDU.
`timescale 1ns / 1ps

module t4t_front #(
    parameter int FILE_BYTES   = t4t_pkg::FILE_BYTES_DEF,
    parameter int MAX_READ_LEN = t4t_pkg::MAX_READ_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [t4t_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           q_full,
    output logic                           q_push,
    output t4t_pkg::desc_t                 q_desc
);
    import t4t_pkg::*;

    logic [7:0]        ins;
    logic [7:0]        p1;
    logic [7:0]        p2;
    logic [7:0]        lc;
    logic [55:0]       data_bytes;
    logic [6:0]        load_address;
    logic [7:0]        load_value;
    logic [ADDR_W-1:0] offset;
    logic              accept;
    logic              has_work;
    logic              fid_match;
    logic [1:0]        sel_reg;
    logic [1:0]        sel_next;

    assign ins          = s_tdata[7:0];
    assign p1           = s_tdata[15:8];
    assign p2           = s_tdata[23:16];
    assign lc           = s_tdata[31:24];
    assign data_bytes   = s_tdata[87:32];
    assign load_address = s_tdata[94:88];
    assign load_value   = s_tdata[102:95];
    assign offset       = {p1, p2};

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && has_work;

    assign fid_match = (lc == LC_FID) && (data_bytes[55:48] == FID_HIGH) &&
                       ((data_bytes[47:40] == FID_CC) || (data_bytes[47:40] == FID_NDEF));

    always_comb
    begin
        q_desc       = '0;
        q_desc.op    = OP_STATUS;
        q_desc.sw1   = SW_ERR1;
        q_desc.sw2   = SW_FUNC2;
        has_work     = 1'b1;
        sel_next     = sel_reg;
        if (s_tuser)
        begin
            // Loads beyond the file are dropped here and never reach the back end.
            q_desc.op    = OP_LOAD;
            q_desc.addr  = {9'd0, load_address};
            q_desc.value = load_value;
            has_work     = ({9'd0, load_address} < ADDR_W'(FILE_BYTES));
        end
        else if (ins == INS_SELECT)
        begin
            priority if (p1 == P1_BY_ID)
            begin
                if (p2 != P2_FIRST)
                begin
                    q_desc.sw1 = SW_OK1;
                    q_desc.sw2 = SW_OK2;
                end
                else if (fid_match)
                begin
                    q_desc.sw1 = SW_OK1;
                    q_desc.sw2 = SW_OK2;
                    sel_next   = (data_bytes[47:40] == FID_CC) ? SEL_CC : SEL_NDEF;
                end
                else
                begin
                    q_desc.sw2 = SW_NOTF2;
                end
            end
            else if (p1 == P1_BY_NAME && p2 == 8'h00 && lc == LC_AID &&
                     data_bytes == NDEF_AID)
            begin
                q_desc.sw1 = SW_OK1;
                q_desc.sw2 = SW_OK2;
            end
            else
            begin
                q_desc.sw2 = SW_FUNC2;
            end
        end
        else if (ins == INS_READ)
        begin
            priority if (sel_reg != SEL_CC && sel_reg != SEL_NDEF)
            begin
                q_desc.sw2 = SW_NOTF2;
            end
            else if (offset > ADDR_W'(FILE_BYTES) || lc > 8'(MAX_READ_LEN))
            begin
                q_desc.sw1 = SW_WARN1;
                q_desc.sw2 = SW_EOF2;
            end
            else
            begin
                q_desc.op   = OP_READ;
                q_desc.addr = offset;
                q_desc.len  = lc[LEN_W-1:0];
                q_desc.cc   = (sel_reg == SEL_CC);
                q_desc.sw1  = SW_OK1;
                q_desc.sw2  = SW_OK2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= SEL_NONE;
        end
        else if (accept)
        begin
            sel_reg <= sel_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_sel_only_on_select: assert property (@(posedge clk) disable iff (!rst_n)
        (sel_reg != $past(sel_reg)) |-> $past(accept && !s_tuser && ins == INS_SELECT))
        else $error("selection changed without a select command");
    a_read_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_desc.op == OP_READ) |-> (q_desc.len <= LEN_W'(MAX_READ_LEN)))
        else $error("read length above limit queued");
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("push attempted into a full queue");
`endif

endmodule

>>> hdl/t4t_back.sv
// Back end: executes queued work, owns the file memory and streams response bytes.
`timescale 1ns / 1ps

module t4t_back #(
    parameter int FILE_BYTES = t4t_pkg::FILE_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           write_protect,
    input  logic           q_empty,
    input  t4t_pkg::desc_t q_head,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);
    import t4t_pkg::*;

    // Loads carry a 7-bit address, so only the first 128 bytes can ever be nonzero.
    localparam int MEM_DEPTH = (FILE_BYTES < 128) ? FILE_BYTES : 128;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DATA = 2'd1;
    localparam logic [1:0] S_SW1  = 2'd2;
    localparam logic [1:0] S_SW2  = 2'd3;

    logic [7:0]           mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] written_reg;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [LEN_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  cnt_next;
    logic              cc_reg;
    logic              cc_next;
    logic [7:0]        sw1_reg;
    logic [7:0]        sw1_next;
    logic [7:0]        sw2_reg;
    logic [7:0]        sw2_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_mem_reg;
    logic              rd_ok_reg;
    logic [7:0]        rd_data_reg;

    logic              adv;
    logic              beat;
    logic [7:0]        beat_byte;
    logic              beat_last;
    logic              beat_mem;
    logic              mem_we;
    logic [MEM_AW-1:0] rd_idx;
    logic [MEM_AW-1:0] wr_idx;

    assign adv    = !out_valid_reg || m_tready;
    assign rd_idx = addr_reg[MEM_AW-1:0];
    assign wr_idx = q_head.addr[MEM_AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        cc_next    = cc_reg;
        sw1_next   = sw1_reg;
        sw2_next   = sw2_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        beat       = 1'b0;
        beat_byte  = 8'h00;
        beat_last  = 1'b0;
        beat_mem   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.op)
                        OP_LOAD:
                        begin
                            mem_we = 1'b1;
                        end
                        OP_READ:
                        begin
                            addr_next  = q_head.addr;
                            cnt_next   = q_head.len;
                            cc_next    = q_head.cc;
                            sw1_next   = q_head.sw1;
                            sw2_next   = q_head.sw2;
                            state_next = (q_head.len == '0) ? S_SW1 : S_DATA;
                        end
                        default:
                        begin
                            sw1_next   = q_head.sw1;
                            sw2_next   = q_head.sw2;
                            state_next = S_SW1;
                        end
                    endcase
                end
            end
            S_DATA:
            begin
                if (adv)
                begin
                    beat = 1'b1;
                    if (cc_reg)
                    begin
                        beat_byte = cc_byte(addr_reg, ADDR_W'(FILE_BYTES), write_protect);
                    end
                    else if (addr_reg < ADDR_W'(MEM_DEPTH))
                    begin
                        beat_mem = 1'b1;
                    end
                    addr_next = addr_reg + 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == LEN_W'(1))
                    begin
                        state_next = S_SW1;
                    end
                end
            end
            S_SW1:
            begin
                if (adv)
                begin
                    beat       = 1'b1;
                    beat_byte  = sw1_reg;
                    state_next = S_SW2;
                end
            end
            S_SW2:
            begin
                if (adv)
                begin
                    beat       = 1'b1;
                    beat_byte  = sw2_reg;
                    beat_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = adv ? beat : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (mem_we)
            begin
                written_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        cnt_reg  <= cnt_next;
        cc_reg   <= cc_next;
        sw1_reg  <= sw1_next;
        sw2_reg  <= sw2_next;
        if (adv)
        begin
            out_byte_reg <= beat_byte;
            out_last_reg <= beat_last;
            out_mem_reg  <= beat_mem;
        end
        if (adv && beat_mem)
        begin
            rd_data_reg <= mem[rd_idx];
            rd_ok_reg   <= written_reg[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx] <= q_head.value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = out_mem_reg ? (rd_ok_reg ? rd_data_reg : 8'h00) : out_byte_reg;

`ifndef NO_ASSERTIONS
    a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("queue popped while a response is in progress");
    a_last_after_sw2: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SW2 && adv) |=> (m_tvalid && m_tlast && state_reg == S_IDLE))
        else $error("final status beat not presented with last");
    a_data_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) |-> (cnt_reg != '0))
        else $error("data phase entered with no bytes left");
`endif

endmodule

>>> hdl/type4_tag_apdu_responder_unit.sv
// Top level of the Type 4 tag APDU responder: front end, work queue and back end.
`timescale 1ns / 1ps

// Usage:
// The slave stream takes one beat per item. s_tuser low means s_tdata holds a decoded
// command APDU; s_tuser high means it holds a host load of one file memory byte.
// The master stream returns each response one byte per beat, data bytes first and the
// two status bytes last, with m_tlast on the final status byte. Loads return nothing.
// cfg_we with cfg_wdata sets the write-access byte of the capability container; write
// it only while no response is outstanding.
// The front end classifies an APDU in the cycle it is accepted and queues it in a
// two-entry queue; the queue, the back-end state register and the output register lie
// between acceptance and the first response beat. The back end sends one byte per cycle
// while m_tready is high; file memory reads are registered.
// s_tready drops only while the queue is full. When m_tready is low the current byte
// holds in the output register and the back end waits, while the front end keeps
// accepting until the queue fills.
// Reset clears the selection to no file, empties the queue and marks every file memory
// byte as zero through per-byte written flags, so the block is ready right after reset.

module type4_tag_apdu_responder_unit #(
    parameter int FILE_BYTES   = t4t_pkg::FILE_BYTES_DEF,
    parameter int MAX_READ_LEN = t4t_pkg::MAX_READ_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // ins[7:0], p1[15:8], p2[23:16], lc[31:24], data_bytes[87:32],
    // load_address[94:88], load_value[102:95], zero[103]
    input  logic [t4t_pkg::IN_DATA_W-1:0] s_tdata,
    // load[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // resp_byte[7:0]
    output logic [7:0]                    m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata
);
    import t4t_pkg::*;

    logic  write_protect_reg;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    desc_t q_desc;
    desc_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_protect_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            write_protect_reg <= cfg_wdata;
        end
    end

    t4t_front #(
        .FILE_BYTES   (FILE_BYTES),
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (q_desc)
    );

    t4t_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_desc),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    t4t_back #(
        .FILE_BYTES (FILE_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .write_protect (write_protect_reg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule
